### src/hslg_pkg.sv
// ----------------------------------------------------------------------------
// hslg_pkg
// Types, register codes and fixed-point constants shared by the palette
// grid color converter.
// ----------------------------------------------------------------------------
package hslg_pkg;

   // grid size along each axis, indexes wrap at these counts
   localparam int unsigned HUE_STEPS_MAX       = 4096;
   localparam int unsigned LIGHTNESS_STEPS_MAX = 4096;

   // fixed-point scale points
   localparam logic [16:0] L_ONE = 17'd65536;   // 1.0 in Q0.16
   localparam logic [15:0] H_MAX = 16'd49151;   // just below 6.0 in Q3.13

   // register reset values
   localparam logic [16:0] LIGHTNESS_BASE_RESET      = 17'd0;
   localparam logic [16:0] LIGHTNESS_INCREMENT_RESET = 17'd16;
   localparam logic [15:0] HUE_BASE_RESET            = 16'd0;
   localparam logic [15:0] HUE_INCREMENT_RESET       = 16'd12;

   // register index on the configuration port (byte address / 4)
   typedef enum logic [1:0] {
      REG_LIGHTNESS_BASE,
      REG_LIGHTNESS_INCREMENT,
      REG_HUE_BASE,
      REG_HUE_INCREMENT
   } reg_index_type;

   // hue sector, each one sixth of the color wheel
   typedef enum logic [2:0] {
      SECTOR_RED_YELLOW,
      SECTOR_YELLOW_GREEN,
      SECTOR_GREEN_CYAN,
      SECTOR_CYAN_BLUE,
      SECTOR_BLUE_MAGENTA,
      SECTOR_MAGENTA_RED
   } sector_type;

   typedef struct packed {
      logic [11:0] hue_index;
      logic [11:0] lightness_index;
   } req_type;

   typedef struct packed {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
   } rsp_type;

   typedef struct packed {
      logic [16:0] lightness_base;
      logic [16:0] lightness_increment;
      logic [15:0] hue_base;
      logic [15:0] hue_increment;
   } cfg_type;

   // handoff from the coordinate half to the mixing half
   typedef struct packed {
      logic        valid;
      logic [16:0] chroma;
      logic [13:0] ramp;
      sector_type  sector;
      logic [16:0] offset;
   } coord_type;

endpackage

### src/hslg_regs.sv
// ----------------------------------------------------------------------------
// hslg_regs
// Configuration registers behind a simple APB-style slave, always ready.
// ----------------------------------------------------------------------------
module hslg_regs (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [3:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready,
   output hslg_pkg::cfg_type    cfg
);

   hslg_pkg::cfg_type       cfg_ff;
   hslg_pkg::cfg_type       cfg_in;
   hslg_pkg::reg_index_type reg_index;
   logic                    write_en;

   assign reg_index = hslg_pkg::reg_index_type'(paddr[3:2]);
   assign write_en  = psel & penable & pwrite;
   assign pready    = 1'b1;

   // write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (reg_index)
            hslg_pkg::REG_LIGHTNESS_BASE:      cfg_in.lightness_base      = pwdata[16:0];
            hslg_pkg::REG_LIGHTNESS_INCREMENT: cfg_in.lightness_increment = pwdata[16:0];
            hslg_pkg::REG_HUE_BASE:            cfg_in.hue_base            = pwdata[15:0];
            hslg_pkg::REG_HUE_INCREMENT:       cfg_in.hue_increment       = pwdata[15:0];
            default:                           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lightness_base      <= hslg_pkg::LIGHTNESS_BASE_RESET;
         cfg_ff.lightness_increment <= hslg_pkg::LIGHTNESS_INCREMENT_RESET;
         cfg_ff.hue_base            <= hslg_pkg::HUE_BASE_RESET;
         cfg_ff.hue_increment       <= hslg_pkg::HUE_INCREMENT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      case (reg_index)
         hslg_pkg::REG_LIGHTNESS_BASE:      prdata = {15'd0, cfg_ff.lightness_base};
         hslg_pkg::REG_LIGHTNESS_INCREMENT: prdata = {15'd0, cfg_ff.lightness_increment};
         hslg_pkg::REG_HUE_BASE:            prdata = {16'd0, cfg_ff.hue_base};
         hslg_pkg::REG_HUE_INCREMENT:       prdata = {16'd0, cfg_ff.hue_increment};
         default:                           prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

### src/hslg_coord.sv
// ----------------------------------------------------------------------------
// hslg_coord
// Cell center to HSL coordinates: scales the indexes (stage 1), then clamps
// lightness and hue and derives chroma, hue ramp, sector and offset (stage 2).
// ----------------------------------------------------------------------------
module hslg_coord (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  hslg_pkg::req_type    req,
   input  hslg_pkg::cfg_type    cfg,
   output hslg_pkg::coord_type  coord
);

   logic [11:0] hue_idx;
   logic [11:0] light_idx;
   logic [29:0] prod_l_in;
   logic [28:0] prod_h_in;

   logic        valid1_ff;
   logic [29:0] prod_l_ff;
   logic [28:0] prod_h_ff;

   logic [29:0] l_sum;
   logic [28:0] h_sum;
   logic [16:0] l_sat;
   logic [15:0] h_clamp;
   logic [17:0] two_l;
   logic [17:0] chroma_wide;
   logic [16:0] chroma;
   logic [13:0] hue_mod;
   logic [14:0] ramp_fall;
   logic [13:0] ramp;

   hslg_pkg::coord_type coord_in;
   hslg_pkg::coord_type coord_ff;

   // wrap indexes onto the grid
   assign hue_idx   = 12'(32'(req.hue_index) % hslg_pkg::HUE_STEPS_MAX);
   assign light_idx = 12'(32'(req.lightness_index) % hslg_pkg::LIGHTNESS_STEPS_MAX);

   // stage 1: increment times (2*index + 1)
   assign prod_l_in = 30'(cfg.lightness_increment) * 30'({light_idx, 1'b1});
   assign prod_h_in = 29'(cfg.hue_increment) * 29'({hue_idx, 1'b1});

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      prod_l_ff <= prod_l_in;
      prod_h_ff <= prod_h_in;
   end

   // stage 2: half, add base, saturate lightness and clamp hue
   assign l_sum   = 30'(prod_l_ff[29:1]) + 30'(cfg.lightness_base);
   assign h_sum   = 29'(prod_h_ff[28:1]) + 29'(cfg.hue_base);
   assign l_sat   = (l_sum > 30'(hslg_pkg::L_ONE)) ? hslg_pkg::L_ONE : l_sum[16:0];
   assign h_clamp = (h_sum > 29'(hslg_pkg::H_MAX)) ? hslg_pkg::H_MAX : h_sum[15:0];

   // chroma = 1 - |2l - 1|
   assign two_l       = {l_sat, 1'b0};
   assign chroma_wide = (two_l >= 18'(hslg_pkg::L_ONE)) ? (18'd131072 - two_l) : two_l;
   assign chroma      = chroma_wide[16:0];

   // triangle ramp over each pair of sectors
   assign hue_mod   = h_clamp[13:0];
   assign ramp_fall = 15'd16384 - {1'b0, hue_mod};
   assign ramp      = hue_mod[13] ? ramp_fall[13:0] : hue_mod;

   always_comb begin
      coord_in.valid  = valid1_ff;
      coord_in.chroma = chroma;
      coord_in.ramp   = ramp;
      coord_in.sector = hslg_pkg::sector_type'(h_clamp[15:13]);
      coord_in.offset = l_sat - {1'b0, chroma[16:1]};
   end

   // stage 2 register, only the valid bit is reset
   always_ff @(posedge clock) begin
      if (reset) begin
         coord_ff.valid <= 1'b0;
      end else begin
         coord_ff.valid <= coord_in.valid;
      end
      coord_ff.chroma <= coord_in.chroma;
      coord_ff.ramp   <= coord_in.ramp;
      coord_ff.sector <= coord_in.sector;
      coord_ff.offset <= coord_in.offset;
   end

   assign coord = coord_ff;

   // chroma never exceeds full scale
   a_chroma_range: assert property (@(posedge clock) disable iff (reset)
      coord_ff.valid |-> coord_ff.chroma <= hslg_pkg::L_ONE)
      else $error("chroma above 1.0");

   // offset plus half chroma is the saturated lightness, so never above 1.0
   a_offset_range: assert property (@(posedge clock) disable iff (reset)
      coord_ff.valid |-> (18'(coord_ff.offset) + 18'(coord_ff.chroma[16:1]))
                         <= 18'(hslg_pkg::L_ONE))
      else $error("lightness offset out of range");

   // ramp peaks at one sector width
   a_ramp_range: assert property (@(posedge clock) disable iff (reset)
      coord_ff.valid |-> coord_ff.ramp <= 14'd8192)
      else $error("hue ramp above one");

endmodule

### src/hslg_mix.sv
// ----------------------------------------------------------------------------
// hslg_mix
// Second chroma product (stage 3), then sector routing, offset add and
// saturation into the output word (stage 4).
// ----------------------------------------------------------------------------
module hslg_mix (
   input  logic                 clock,
   input  logic                 reset,
   input  hslg_pkg::coord_type  coord,
   output logic                 out_valid,
   output hslg_pkg::rsp_type    out_data
);

   logic [29:0] prod_x;

   logic                 valid3_ff;
   logic [16:0]          x_ff;
   logic [16:0]          chroma_ff;
   logic [16:0]          offset_ff;
   hslg_pkg::sector_type sector_ff;

   logic [16:0] red_raw;
   logic [16:0] green_raw;
   logic [16:0] blue_raw;
   logic [17:0] red_sum;
   logic [17:0] green_sum;
   logic [17:0] blue_sum;

   logic              valid4_ff;
   hslg_pkg::rsp_type rsp_in;
   hslg_pkg::rsp_type rsp_ff;

   // stage 3: x = chroma * ramp, Q0.16 after dropping 13 fraction bits
   assign prod_x = 30'(coord.chroma) * 30'(coord.ramp);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid3_ff <= 1'b0;
      end else begin
         valid3_ff <= coord.valid;
      end
   end

   always_ff @(posedge clock) begin
      x_ff      <= prod_x[29:13];
      chroma_ff <= coord.chroma;
      offset_ff <= coord.offset;
      sector_ff <= coord.sector;
   end

   // stage 4: route chroma and x by sector
   always_comb begin
      case (sector_ff)
         hslg_pkg::SECTOR_RED_YELLOW: begin
            red_raw = chroma_ff; green_raw = x_ff;      blue_raw = 17'd0;
         end
         hslg_pkg::SECTOR_YELLOW_GREEN: begin
            red_raw = x_ff;      green_raw = chroma_ff; blue_raw = 17'd0;
         end
         hslg_pkg::SECTOR_GREEN_CYAN: begin
            red_raw = 17'd0;     green_raw = chroma_ff; blue_raw = x_ff;
         end
         hslg_pkg::SECTOR_CYAN_BLUE: begin
            red_raw = 17'd0;     green_raw = x_ff;      blue_raw = chroma_ff;
         end
         hslg_pkg::SECTOR_BLUE_MAGENTA: begin
            red_raw = x_ff;      green_raw = 17'd0;     blue_raw = chroma_ff;
         end
         default: begin
            red_raw = chroma_ff; green_raw = 17'd0;     blue_raw = x_ff;
         end
      endcase
   end

   // add lightness offset and saturate at full scale
   assign red_sum   = 18'(red_raw)   + 18'(offset_ff);
   assign green_sum = 18'(green_raw) + 18'(offset_ff);
   assign blue_sum  = 18'(blue_raw)  + 18'(offset_ff);

   always_comb begin
      rsp_in.red   = (red_sum   > 18'd65535) ? 16'hFFFF : red_sum[15:0];
      rsp_in.green = (green_sum > 18'd65535) ? 16'hFFFF : green_sum[15:0];
      rsp_in.blue  = (blue_sum  > 18'd65535) ? 16'hFFFF : blue_sum[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid4_ff <= 1'b0;
      end else begin
         valid4_ff <= valid3_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign out_valid = valid4_ff;
   assign out_data  = rsp_ff;

   // x scales chroma by a ramp of at most one
   a_x_below_chroma: assert property (@(posedge clock) disable iff (reset)
      valid3_ff |-> x_ff <= chroma_ff)
      else $error("x exceeds chroma");

   // the dropped sector codes never reach the router
   a_sector_range: assert property (@(posedge clock) disable iff (reset)
      valid3_ff |-> sector_ff != 3'd6 && sector_ff != 3'd7)
      else $error("hue sector beyond six");

endmodule

### src/hsl_grid_to_rgb.sv
// ----------------------------------------------------------------------------
// hsl_grid_to_rgb
// Palette grid cell (hue index, lightness index) to saturated RGB color.
// ----------------------------------------------------------------------------
// Pipeline: the rgb word strobes on rsp_valid out of the last of four register
//   stages, two of them multiplier stages, once start is taken.
// Throughput: one word per cycle; busy stays low, there is no stall path.
// Reset: synchronous, clears the pipeline valid bits and loads the register
//   defaults; words in flight at reset are dropped.
module hsl_grid_to_rgb (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  hslg_pkg::req_type    req_data,
   output logic                 rsp_valid,
   output hslg_pkg::rsp_type    rsp_data,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [3:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);

   hslg_pkg::cfg_type   cfg;
   hslg_pkg::coord_type coord;
   logic                accept;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // configuration registers
   hslg_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // index scaling and hsl coordinates
   hslg_coord u_coord (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .req      (req_data),
      .cfg      (cfg),
      .coord    (coord)
   );

   // channel mixing and output register
   hslg_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .coord     (coord),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

   // every accepted word comes out on rsp_valid
   a_word_out: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##4 rsp_valid)
      else $error("accepted word lost in pipeline");

   // no word appears without an earlier accepted start
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 4))
      else $error("result word without a start");

endmodule

### test/tb_hsl_grid_to_rgb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hsl_grid_to_rgb
// Self-checking bench for the palette grid color converter. Cells go in on
// the start/busy command port and every rgb word is checked field by field
// against a bit-exact fixed-point predictor. The register file is programmed
// over the APB port and read back, and settings include the defaults, the
// all-zero and all-ones extremes, directed corners and random sweeps.
// ----------------------------------------------------------------------------
module tb_hsl_grid_to_rgb;

   localparam int unsigned STALL_LIMIT   = 2000;
   localparam int unsigned SETTLE_CYCLES = 6;
   localparam int unsigned PRINT_LIMIT   = 100;
   localparam longint unsigned H_ONE_SECTOR  = 8192;
   localparam longint unsigned H_TWO_SECTORS = 16384;
   localparam longint unsigned CHANNEL_FULL  = 65535;

   logic              clock    = 1'b0;
   logic              reset    = 1'b1;
   logic              start    = 1'b0;
   logic              busy;
   hslg_pkg::req_type req_data = '0;
   logic              rsp_valid;
   hslg_pkg::rsp_type rsp_data;
   logic              psel     = 1'b0;
   logic              penable  = 1'b0;
   logic              pwrite   = 1'b0;
   logic [3:0]        paddr    = '0;
   logic [31:0]       pwdata   = '0;
   logic [31:0]       prdata;
   logic              pready;

   // bench copy of the register file
   hslg_pkg::cfg_type shadow_cfg;
   hslg_pkg::rsp_type color_queue[$];
   int unsigned       error_count  = 0;
   int unsigned       stall_cycles = 0;
   bit                gaps_on      = 1'b1;
   int unsigned       gap_percent  = 0;

   hsl_grid_to_rgb u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // 125 MHz clock
   initial begin
      forever #4 clock = ~clock;
   end

   task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
      error_count++;
      if (error_count <= PRINT_LIMIT) begin
         $display("ERROR at %0t: %s: expected %0h, got %0h", $realtime, what, want, got);
      end
   endtask

   function automatic logic [15:0] clip_channel(longint unsigned level);
      return (level > CHANNEL_FULL) ? 16'hFFFF : 16'(level);
   endfunction

   // expected rgb word for one cell under the current register settings
   function automatic hslg_pkg::rsp_type cell_color(hslg_pkg::req_type grid_pos);
      longint unsigned      step, index, light, hue, chroma, hue_mod, ramp, tint, offset;
      longint unsigned      red, green, blue;
      hslg_pkg::sector_type sector;
      hslg_pkg::rsp_type    rgb;

      // cell centers, lightness saturates at one, hue clamps below six
      step  = shadow_cfg.lightness_increment;
      index = grid_pos.lightness_index % hslg_pkg::LIGHTNESS_STEPS_MAX;
      light = ((step * (2 * index + 1)) >> 1) + shadow_cfg.lightness_base;
      if (light > hslg_pkg::L_ONE) light = hslg_pkg::L_ONE;
      step  = shadow_cfg.hue_increment;
      index = grid_pos.hue_index % hslg_pkg::HUE_STEPS_MAX;
      hue   = ((step * (2 * index + 1)) >> 1) + shadow_cfg.hue_base;
      if (hue > hslg_pkg::H_MAX) hue = hslg_pkg::H_MAX;

      // chroma and the triangular ramp inside a sector pair
      chroma  = (2 * light >= hslg_pkg::L_ONE) ?
                2 * longint'(hslg_pkg::L_ONE) - 2 * light : 2 * light;
      hue_mod = hue % H_TWO_SECTORS;
      ramp    = (hue_mod >= H_ONE_SECTOR) ? H_TWO_SECTORS - hue_mod : hue_mod;
      tint    = (chroma * ramp) >> 13;
      offset  = light - (chroma >> 1);
      sector  = hslg_pkg::sector_type'(3'(hue >> 13));

      case (sector)
         hslg_pkg::SECTOR_RED_YELLOW: begin
            red = chroma; green = tint;   blue = 0;
         end
         hslg_pkg::SECTOR_YELLOW_GREEN: begin
            red = tint;   green = chroma; blue = 0;
         end
         hslg_pkg::SECTOR_GREEN_CYAN: begin
            red = 0;      green = chroma; blue = tint;
         end
         hslg_pkg::SECTOR_CYAN_BLUE: begin
            red = 0;      green = tint;   blue = chroma;
         end
         hslg_pkg::SECTOR_BLUE_MAGENTA: begin
            red = tint;   green = 0;      blue = chroma;
         end
         default: begin
            // magenta to red
            red = chroma; green = 0;      blue = tint;
         end
      endcase

      rgb.red   = clip_channel(red + offset);
      rgb.green = clip_channel(green + offset);
      rgb.blue  = clip_channel(blue + offset);
      return rgb;
   endfunction

   function automatic logic [31:0] register_value(hslg_pkg::reg_index_type which);
      case (which)
         hslg_pkg::REG_LIGHTNESS_BASE:      return 32'(shadow_cfg.lightness_base);
         hslg_pkg::REG_LIGHTNESS_INCREMENT: return 32'(shadow_cfg.lightness_increment);
         hslg_pkg::REG_HUE_BASE:            return 32'(shadow_cfg.hue_base);
         default:                           return 32'(shadow_cfg.hue_increment);
      endcase
   endfunction

   function automatic hslg_pkg::req_type random_cell();
      hslg_pkg::req_type grid_pos;
      grid_pos.hue_index       = 12'($urandom_range(0, 4095));
      grid_pos.lightness_index = 12'($urandom_range(0, 4095));
      // lean on the index extremes now and then
      case ($urandom_range(0, 15))
         0: grid_pos.hue_index       = '0;
         1: grid_pos.hue_index       = '1;
         2: grid_pos.lightness_index = '0;
         3: grid_pos.lightness_index = '1;
         default: ;
      endcase
      return grid_pos;
   endfunction

   function automatic hslg_pkg::req_type make_cell(int unsigned hue_index,
                                                   int unsigned lightness_index);
      hslg_pkg::req_type grid_pos;
      grid_pos.hue_index       = 12'(hue_index);
      grid_pos.lightness_index = 12'(lightness_index);
      return grid_pos;
   endfunction

   // one cell on the command port, with an optional idle burst ahead of it
   task automatic send_cell(hslg_pkg::req_type grid_pos);
      if (gaps_on && $urandom_range(0, 99) < gap_percent) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= grid_pos;
      do @(posedge clock); while (busy);
      color_queue = {color_queue, cell_color(grid_pos)};
   endtask

   task automatic send_random_cells(int unsigned count);
      repeat (count) send_cell(random_cell());
   endtask

   // stop issuing and let every word in flight come out
   task automatic wait_for_drain();
      start <= 1'b0;
      while (color_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(hslg_pkg::reg_index_type which, logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {which, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      // only the register width is kept
      case (which)
         hslg_pkg::REG_LIGHTNESS_BASE:      shadow_cfg.lightness_base      = value[16:0];
         hslg_pkg::REG_LIGHTNESS_INCREMENT: shadow_cfg.lightness_increment = value[16:0];
         hslg_pkg::REG_HUE_BASE:            shadow_cfg.hue_base            = value[15:0];
         default:                           shadow_cfg.hue_increment       = value[15:0];
      endcase
      @(posedge clock);
   endtask

   task automatic read_register(hslg_pkg::reg_index_type which);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {which, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== register_value(which)) begin
         report_mismatch($sformatf("readback of %s", which.name()),
                         register_value(which), prdata);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_config(logic [31:0] light_base, logic [31:0] light_step,
                                 logic [31:0] hue_start, logic [31:0] hue_step);
      wait_for_drain();
      write_register(hslg_pkg::REG_LIGHTNESS_BASE, light_base);
      write_register(hslg_pkg::REG_LIGHTNESS_INCREMENT, light_step);
      write_register(hslg_pkg::REG_HUE_BASE, hue_start);
      write_register(hslg_pkg::REG_HUE_INCREMENT, hue_step);
      read_register(hslg_pkg::REG_LIGHTNESS_BASE);
      read_register(hslg_pkg::REG_LIGHTNESS_INCREMENT);
      read_register(hslg_pkg::REG_HUE_BASE);
      read_register(hslg_pkg::REG_HUE_INCREMENT);
   endtask

   // random settings: in half the draws, spans that sweep the whole wheel and gray ramp
   task automatic program_random_config();
      case ($urandom_range(0, 3))
         0, 1: program_config($urandom_range(0, 16384), $urandom_range(0, 20),
                              $urandom_range(0, 8192), $urandom_range(0, 14));
         2:    program_config($urandom(), $urandom(), $urandom(), $urandom());
         default: program_config($urandom_range(0, 65536), $urandom_range(0, 65536),
                                 $urandom_range(0, 49151), $urandom_range(0, 49151));
      endcase
   endtask

   task automatic test_register_defaults();
      read_register(hslg_pkg::REG_LIGHTNESS_BASE);
      read_register(hslg_pkg::REG_LIGHTNESS_INCREMENT);
      read_register(hslg_pkg::REG_HUE_BASE);
      read_register(hslg_pkg::REG_HUE_INCREMENT);
   endtask

   task automatic test_directed_cells();
      gap_percent = 0;
      // reset settings: grid corners and the middle of every sector
      send_cell(make_cell(0, 0));
      send_cell(make_cell(4095, 4095));
      send_cell(make_cell(0, 4095));
      send_cell(make_cell(4095, 0));
      for (int unsigned k = 0; k < 6; k++) begin
         send_cell(make_cell(k * 683 + 340, 2047));
      end
      // lightness exactly one half: full chroma drives a channel to full scale
      program_config(32760, 16, 0, 12);
      send_cell(make_cell(0, 0));
      send_cell(make_cell(682, 0));
      send_cell(make_cell(683, 0));
      send_cell(make_cell(4095, 0));
      // lightness above one gives white, hue past six is clamped
      program_config(65536, 16, 49151, 12);
      send_cell(make_cell(0, 0));
      send_cell(make_cell(4095, 4095));
      send_cell(make_cell(2048, 100));
      // clamped hue at a quarter lightness
      program_config(16384, 0, 49151, 65535);
      send_cell(make_cell(0, 1));
      send_cell(make_cell(4095, 4095));
   endtask

   task automatic test_register_extremes();
      gap_percent = 20;
      program_config('0, '0, '0, '0);
      send_random_cells(40);
      program_config('1, '1, '1, '1);
      send_random_cells(40);
   endtask

   task automatic test_random_settings();
      repeat (7) begin
         program_random_config();
         case ($urandom_range(0, 2))
            0: gap_percent = 0;
            1: gap_percent = 8;
            default: gap_percent = 35;
         endcase
         send_random_cells(130);
      end
   endtask

   task automatic test_back_to_back();
      gaps_on = 1'b0;
      program_config($urandom_range(0, 16384), $urandom_range(0, 20),
                     $urandom_range(0, 8192), $urandom_range(0, 14));
      send_random_cells(150);
   endtask

   // result checking and the no-progress watchdog
   always @(posedge clock) begin
      hslg_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (color_queue.size() == 0) begin
            report_mismatch("rgb word with nothing expected", 0, rsp_data);
         end else begin
            want = color_queue.pop_front();
            if (rsp_data.red !== want.red)     report_mismatch("red", want.red, rsp_data.red);
            if (rsp_data.green !== want.green) report_mismatch("green", want.green, rsp_data.green);
            if (rsp_data.blue !== want.blue)   report_mismatch("blue", want.blue, rsp_data.blue);
         end
      end
      if (reset || (start && !busy) || rsp_valid || (psel && penable && pready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // test sequence
   initial begin
      shadow_cfg.lightness_base      = hslg_pkg::LIGHTNESS_BASE_RESET;
      shadow_cfg.lightness_increment = hslg_pkg::LIGHTNESS_INCREMENT_RESET;
      shadow_cfg.hue_base            = hslg_pkg::HUE_BASE_RESET;
      shadow_cfg.hue_increment       = hslg_pkg::HUE_INCREMENT_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_register_defaults();
      test_directed_cells();
      test_register_extremes();
      test_random_settings();
      test_back_to_back();

      wait_for_drain();
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
